// ----- design/csc_pkg.sv -----
// Shared types and constants for the crank cadence meter.
// No dependencies; imported by csc_front, csc_back, the top level and the bench.
package csc_pkg;

  localparam logic [7:0] FLAGS_CRANK       = 8'h02;
  localparam logic [7:0] FLAGS_WHEEL_CRANK = 8'h03;

  localparam logic [4:0] REVS_POS_CRANK = 5'd1;
  localparam logic [4:0] TIME_POS_CRANK = 5'd3;
  localparam logic [4:0] REVS_POS_WHEEL = 5'd7;
  localparam logic [4:0] TIME_POS_WHEEL = 5'd9;
  // lowest index of the final byte for a complete packet
  localparam logic [4:0] LAST_MIN_CRANK = 5'd4;
  localparam logic [4:0] LAST_MIN_WHEEL = 5'd10;
  localparam logic [4:0] POS_MAX        = 5'd31;

  localparam logic [11:0] CADENCE_MAX = 12'd4095;
  localparam logic [15:0] MS_MAX      = 16'hFFFF;
  localparam logic [15:0] TIMEOUT_RST = 16'd2000;
  localparam logic [7:0]  LIMIT_RST   = 8'd255;

  localparam logic [1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_LIMIT   = 2'd1;

  typedef enum logic [2:0] {
    ST_UPDATED = 3'd0,
    ST_HELD    = 3'd1,
    ST_TIMEOUT = 3'd2,
    ST_SHORT   = 3'd3,
    ST_IGNORED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_PKT_OK,
    CMD_PKT_SHORT,
    CMD_PKT_IGNORED
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [15:0] revs;
    logic [15:0] etime;
  } cmd_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [7:0]  limit_rpm;
  } cfg_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CALC,
    B_CHECK,
    B_DIV,
    B_DONE
  } back_state_t;

endpackage

// ----- design/csc_front.sv -----
// Front end: assembles notification bytes and classifies each packet end.
// Emits one command per tick or final byte. Depends on csc_pkg.
module csc_front import csc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       action,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       cmd_push,
  output cmd_t       cmd
);

  logic [4:0]  pos_r;
  logic [7:0]  flags_r;
  logic [15:0] revs_r;
  logic [15:0] time_r;

  logic [7:0]  flags_cur;
  logic [15:0] revs_cur;
  logic [15:0] time_cur;
  logic [4:0]  rpos;
  logic [4:0]  tpos;
  logic        byte_acc;

  assign byte_acc = accept && !action;

  always_comb begin
    flags_cur = (pos_r == 5'd0) ? data_byte : flags_r;
    rpos      = (flags_r == FLAGS_WHEEL_CRANK) ? REVS_POS_WHEEL : REVS_POS_CRANK;
    tpos      = (flags_r == FLAGS_WHEEL_CRANK) ? TIME_POS_WHEEL : TIME_POS_CRANK;
    revs_cur  = revs_r;
    time_cur  = time_r;
    if (pos_r == 5'd0) begin
      revs_cur = '0;
      time_cur = '0;
    end else if (pos_r == rpos) begin
      revs_cur[7:0] = data_byte;
    end else if (pos_r == rpos + 5'd1) begin
      revs_cur[15:8] = data_byte;
    end else if (pos_r == tpos) begin
      time_cur[7:0] = data_byte;
    end else if (pos_r == tpos + 5'd1) begin
      time_cur[15:8] = data_byte;
    end
  end

  always_comb begin
    cmd_push  = accept && (action || last_byte);
    cmd.revs  = revs_cur;
    cmd.etime = time_cur;
    if (action) begin
      cmd.kind = CMD_TICK;
    end else if (flags_cur == FLAGS_CRANK) begin
      cmd.kind = (pos_r < LAST_MIN_CRANK) ? CMD_PKT_SHORT : CMD_PKT_OK;
    end else if (flags_cur == FLAGS_WHEEL_CRANK) begin
      cmd.kind = (pos_r < LAST_MIN_WHEEL) ? CMD_PKT_SHORT : CMD_PKT_OK;
    end else begin
      cmd.kind = CMD_PKT_IGNORED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (byte_acc) begin
      if (last_byte) begin
        pos_r <= '0;
      end else if (pos_r != POS_MAX) begin
        pos_r <= pos_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_acc) begin
      flags_r <= flags_cur;
      revs_r  <= revs_cur;
      time_r  <= time_cur;
    end
  end

endmodule

// ----- design/csc_cmd_fifo.sv -----
// Short command queue between front and back end.
// Register based; depends on csc_pkg only through the importing modules.
module csc_cmd_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ----- design/csc_div.sv -----
// Serial restoring divider, one quotient bit per cycle.
// Quotient must fit in QW bits; no dependencies.
module csc_div #(
  parameter int QW = 12,
  parameter int NW = 36
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [15:0]   divisor,
  output logic          done,
  output logic [QW-1:0] quotient
);

  localparam int CNTW = $clog2(QW);

  logic            busy_r;
  logic            done_r;
  logic [CNTW-1:0] cnt_r;
  logic [NW-1:0]   rem_r;
  logic [NW-1:0]   dsr_r;
  logic [QW-1:0]   quo_r;
  logic            ge;

  assign ge       = (rem_r >= dsr_r);
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(QW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - CNTW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsr_r <= NW'(divisor) << (QW - 1);
      quo_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dsr_r;
      end
      dsr_r <= dsr_r >> 1;
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

endmodule

// ----- design/csc_back.sv -----
// Back end: keeps previous counts, works out cadence and drives the result slot.
// Depends on csc_pkg and csc_div.
module csc_back import csc_pkg::*; #(
  parameter int FRAC = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  input  logic        cmd_empty,
  output logic        cmd_pop,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] cadence_q4,
  output status_t     status,
  output logic [15:0] crank_revs,
  output logic [15:0] event_time
);

  localparam int QW = 8 + FRAC;
  localparam int NW = 32 + FRAC;

  back_state_t state_r, state_nxt;
  logic [15:0] ms_r, ms_nxt;
  logic [11:0] cad_r, cad_nxt;
  logic [15:0] prev_revs_r, prev_revs_nxt;
  logic [15:0] prev_time_r, prev_time_nxt;
  logic [15:0] cur_revs_r, cur_revs_nxt;
  logic [15:0] cur_time_r, cur_time_nxt;
  logic [15:0] drev_r, drev_nxt;
  logic [15:0] dt_r, dt_nxt;
  logic [31:0] num_r, num_nxt;
  logic [23:0] prod_r, prod_nxt;
  status_t     st_r, st_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [11:0] o_cad_r, o_cad_nxt;
  status_t     o_st_r, o_st_nxt;
  logic [15:0] o_revs_r, o_revs_nxt;
  logic [15:0] o_time_r, o_time_nxt;

  logic          out_free;
  logic          div_start;
  logic          div_done;
  logic [QW-1:0] div_quo;
  logic [15:0]   quo16;
  logic [11:0]   cad_sat;

  csc_div #(.QW(QW), .NW(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (NW'(num_r) << FRAC),
    .divisor  (dt_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign quo16    = 16'(div_quo);
  assign cad_sat  = (quo16 > 16'(CADENCE_MAX)) ? CADENCE_MAX : quo16[11:0];
  assign out_free = !out_valid_r || pop;

  always_comb begin
    state_nxt     = state_r;
    cmd_pop       = 1'b0;
    div_start     = 1'b0;
    ms_nxt        = ms_r;
    cad_nxt       = cad_r;
    prev_revs_nxt = prev_revs_r;
    prev_time_nxt = prev_time_r;
    cur_revs_nxt  = cur_revs_r;
    cur_time_nxt  = cur_time_r;
    drev_nxt      = drev_r;
    dt_nxt        = dt_r;
    num_nxt       = num_r;
    prod_nxt      = prod_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r && !pop;
    o_cad_nxt     = o_cad_r;
    o_st_nxt      = o_st_r;
    o_revs_nxt    = o_revs_r;
    o_time_nxt    = o_time_r;
    unique case (state_r)
      B_IDLE: begin
        if (!cmd_empty) begin
          unique case (cmd.kind)
            CMD_TICK: begin
              cmd_pop = 1'b1;
              if (ms_r != MS_MAX) begin
                ms_nxt = ms_r + 16'd1;
              end
            end
            CMD_PKT_OK: begin
              cmd_pop       = 1'b1;
              cur_revs_nxt  = cmd.revs;
              cur_time_nxt  = cmd.etime;
              drev_nxt      = cmd.revs - prev_revs_r;
              dt_nxt        = cmd.etime - prev_time_r;
              prev_revs_nxt = cmd.revs;
              prev_time_nxt = cmd.etime;
              state_nxt     = B_CALC;
            end
            CMD_PKT_SHORT, CMD_PKT_IGNORED: begin
              if (out_free) begin
                cmd_pop       = 1'b1;
                out_valid_nxt = 1'b1;
                o_cad_nxt     = cad_r;
                o_st_nxt      = (cmd.kind == CMD_PKT_SHORT) ? ST_SHORT : ST_IGNORED;
                o_revs_nxt    = '0;
                o_time_nxt    = '0;
              end
            end
            default: ;
          endcase
        end
      end
      B_CALC: begin
        if (drev_r != 16'd0 && dt_r != 16'd0) begin
          ms_nxt    = '0;
          // revs * 61440 = revs * 2^16 - revs * 2^12
          num_nxt   = {drev_r, 16'h0000} - {4'h0, drev_r, 12'h000};
          prod_nxt  = 24'(cfg.limit_rpm) * 24'(dt_r);
          state_nxt = B_CHECK;
        end else if (ms_r > cfg.timeout_ms) begin
          cad_nxt   = '0;
          st_nxt    = ST_TIMEOUT;
          state_nxt = B_DONE;
        end else begin
          st_nxt    = ST_HELD;
          state_nxt = B_DONE;
        end
      end
      B_CHECK: begin
        if (num_r < 32'(prod_r)) begin
          div_start = 1'b1;
          state_nxt = B_DIV;
        end else begin
          st_nxt    = ST_HELD;
          state_nxt = B_DONE;
        end
      end
      B_DIV: begin
        if (div_done) begin
          cad_nxt   = cad_sat;
          st_nxt    = ST_UPDATED;
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          o_cad_nxt     = cad_r;
          o_st_nxt      = st_r;
          o_revs_nxt    = cur_revs_r;
          o_time_nxt    = cur_time_r;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      ms_r        <= '0;
      cad_r       <= '0;
      prev_revs_r <= '0;
      prev_time_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ms_r        <= ms_nxt;
      cad_r       <= cad_nxt;
      prev_revs_r <= prev_revs_nxt;
      prev_time_r <= prev_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_revs_r <= cur_revs_nxt;
    cur_time_r <= cur_time_nxt;
    drev_r     <= drev_nxt;
    dt_r       <= dt_nxt;
    num_r      <= num_nxt;
    prod_r     <= prod_nxt;
    st_r       <= st_nxt;
    o_cad_r    <= o_cad_nxt;
    o_st_r     <= o_st_nxt;
    o_revs_r   <= o_revs_nxt;
    o_time_r   <= o_time_nxt;
  end

  assign empty      = !out_valid_r;
  assign cadence_q4 = o_cad_r;
  assign status     = o_st_r;
  assign crank_revs = o_revs_r;
  assign event_time = o_time_r;

endmodule

// ----- design/csc_crank_cadence_meter.sv -----
// Crank cadence meter: takes notification bytes and millisecond ticks through
// a queue-style port and returns one result per notification. A byte or a tick
// is taken every cycle while the command queue (CMD_DEPTH entries) has room;
// only ticks and final bytes occupy it. The back end retires a tick, a short
// or an ignored packet from its idle state, a packet with no crank change
// through its calc and done states, and a good packet through calc, check,
// the serial divider (one quotient bit per cycle) and done. Results wait in a
// one-entry output register. Configuration: index 0 timeout_ms, index 1 cadence
// limit in rpm (bits 7:0); other indices are dropped. Depends on csc_pkg,
// csc_front, csc_cmd_fifo, csc_div and csc_back.
module csc_crank_cadence_meter import csc_pkg::*; #(
  parameter int CADENCE_FRAC_BITS = 4,
  parameter int CMD_DEPTH         = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_action,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] out_cadence_q4,
  output logic [2:0]  out_status,
  output logic [15:0] out_crank_revs,
  output logic [15:0] out_event_time,
  input  logic        valid,
  output logic        ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg_r;
  logic    accept;
  logic    cmd_push;
  logic    cmd_pop;
  logic    cmd_empty;
  cmd_t    cmd_in;
  cmd_t    cmd_out;
  status_t status;

  assign ready  = 1'b1;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ms <= TIMEOUT_RST;
      cfg_r.limit_rpm  <= LIMIT_RST;
    end else if (valid && ready) begin
      if (cfg_index == CFG_TIMEOUT) begin
        cfg_r.timeout_ms <= cfg_data;
      end else if (cfg_index == CFG_LIMIT) begin
        cfg_r.limit_rpm <= cfg_data[7:0];
      end
    end
  end

  csc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (in_action),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  csc_cmd_fifo #(.DEPTH(CMD_DEPTH), .WIDTH($bits(cmd_t))) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .full  (full),
    .empty (cmd_empty)
  );

  csc_back #(.FRAC(CADENCE_FRAC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd_out),
    .cmd_empty  (cmd_empty),
    .cmd_pop    (cmd_pop),
    .empty      (empty),
    .pop        (pop),
    .cadence_q4 (out_cadence_q4),
    .status     (status),
    .crank_revs (out_crank_revs),
    .event_time (out_event_time)
  );

  assign out_status = status;

  a_cmd_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_push && cmd_empty) |=> !cmd_empty)
    else $error("queued command lost");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (status == ST_SHORT || status == ST_IGNORED))
      |-> (out_crank_revs == 16'd0 && out_event_time == 16'd0))
    else $error("rejected packet carries counts");

  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && status == ST_TIMEOUT) |-> (out_cadence_q4 == 12'd0))
    else $error("timeout without zero cadence");

endmodule

// ----- bench/csc_crank_cadence_meter_tb.sv -----
// Self-checking bench for csc_crank_cadence_meter: byte/tick stimulus with a
// cycle-free cadence predictor and an in-order result scoreboard.
// Depends on csc_pkg and the csc_crank_cadence_meter RTL.
module csc_crank_cadence_meter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csc_pkg::*;

  localparam int FRAC_BITS   = 4;
  localparam int RPM_SCALE   = 61440;  // 60 s x 1024 time units
  localparam int MAX_IDLE    = 5000;
  localparam int TAIL_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 140;
  localparam int N_PHASES    = 8;
  localparam logic [1:0] CFG_SPARE_A = 2'd2;
  localparam logic [1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [11:0] cadence;
    status_t     status;
    logic [15:0] revs;
    logic [15:0] etime;
  } result_t;

  typedef struct {
    logic    act;
    logic [7:0] b;
    logic    lst;
    bit      typed;
    result_t res;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic        in_action;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        empty;
  logic        pop;
  logic [11:0] out_cadence_q4;
  logic [2:0]  out_status;
  logic [15:0] out_crank_revs;
  logic [15:0] out_event_time;
  logic        valid;
  logic        ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // predictor state
  logic [4:0]  frame_pos;
  logic [7:0]  frame_flags;
  logic [15:0] revs_acc;
  logic [15:0] time_acc;
  logic [15:0] last_revs;
  logic [15:0] last_time;
  logic [11:0] cadence_now;
  logic [15:0] ms_idle;
  logic [15:0] timeout_reg;
  logic [7:0]  limit_reg;

  result_t     cadence_q[$];
  row_t        dir_rows[$];
  bit          typed_valid;
  result_t     typed_res;
  int          errors;
  int          items_sent;
  int          idle_cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_req;
  int          hold_left;
  int          tick_max;
  logic [15:0] gen_revs;
  logic [15:0] gen_time;

  csc_crank_cadence_meter #(.CADENCE_FRAC_BITS(FRAC_BITS)) uut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic meter_step(input logic act, input logic [7:0] b, input logic lst,
                            output bit got, output result_t r);
    logic [4:0]  idx;
    logic [4:0]  rlo;
    logic [4:0]  tlo;
    logic [15:0] drev;
    logic [15:0] dt;
    logic [63:0] num;
    logic [63:0] q;
    got = 1'b0;
    r = '0;
    if (act) begin
      if (ms_idle != MS_MAX) ms_idle = ms_idle + 16'd1;
    end else begin
      idx = frame_pos;
      if (idx == 5'd0) begin
        frame_flags = b;
        revs_acc = '0;
        time_acc = '0;
      end else begin
        rlo = (frame_flags == FLAGS_WHEEL_CRANK) ? REVS_POS_WHEEL : REVS_POS_CRANK;
        tlo = (frame_flags == FLAGS_WHEEL_CRANK) ? TIME_POS_WHEEL : TIME_POS_CRANK;
        if (idx == rlo) revs_acc[7:0] = b;
        else if (idx == rlo + 5'd1) revs_acc[15:8] = b;
        else if (idx == tlo) time_acc[7:0] = b;
        else if (idx == tlo + 5'd1) time_acc[15:8] = b;
      end
      if (frame_pos != POS_MAX) frame_pos = frame_pos + 5'd1;
      if (lst) begin
        frame_pos = '0;
        got = 1'b1;
        if (frame_flags != FLAGS_CRANK && frame_flags != FLAGS_WHEEL_CRANK) begin
          r.status = ST_IGNORED;
        end else if ((frame_flags == FLAGS_CRANK && idx < LAST_MIN_CRANK) ||
                     (frame_flags == FLAGS_WHEEL_CRANK && idx < LAST_MIN_WHEEL)) begin
          r.status = ST_SHORT;
        end else begin
          drev = revs_acc - last_revs;
          dt = time_acc - last_time;
          if (drev != 16'd0 && dt != 16'd0) begin
            num = 64'(drev) * 64'(RPM_SCALE);
            r.status = ST_HELD;
            if (num < 64'(limit_reg) * 64'(dt)) begin
              q = (num << FRAC_BITS) / 64'(dt);
              cadence_now = (q > 64'(CADENCE_MAX)) ? CADENCE_MAX : q[11:0];
              r.status = ST_UPDATED;
            end
            ms_idle = '0;
          end else if (ms_idle > timeout_reg) begin
            cadence_now = '0;
            r.status = ST_TIMEOUT;
          end else begin
            r.status = ST_HELD;
          end
          last_revs = revs_acc;
          last_time = time_acc;
          r.revs = revs_acc;
          r.etime = time_acc;
        end
        r.cadence = cadence_now;
      end
    end
  endtask

  // transfer monitor and scoreboard
  always @(posedge clk) begin
    bit      got;
    result_t r;
    result_t e;
    if (rst_n) begin
      if (push && !full) begin
        meter_step(in_action, in_data_byte, in_last_byte, got, r);
        if (got) cadence_q.push_back(typed_valid ? typed_res : r);
      end
      if (pop && !empty) begin
        if (cadence_q.size() == 0) begin
          $error("result with nothing expected: cadence %0d status %0d",
                 out_cadence_q4, out_status);
          errors++;
        end else begin
          e = cadence_q.pop_front();
          if (out_cadence_q4 !== e.cadence) begin
            $error("cadence_q4: expected %0d, got %0d", e.cadence, out_cadence_q4);
            errors++;
          end
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status);
            errors++;
          end
          if (out_crank_revs !== e.revs) begin
            $error("crank_revs: expected %0d, got %0d", e.revs, out_crank_revs);
            errors++;
          end
          if (out_event_time !== e.etime) begin
            $error("event_time: expected %0d, got %0d", e.etime, out_event_time);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (valid && ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= MAX_IDLE) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    pop = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic act, input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_action <= act;
    in_data_byte <= b;
    in_last_byte <= lst;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] d);
    valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!ready) @(posedge clk);
    case (idx)
      CFG_TIMEOUT: timeout_reg = d;
      CFG_LIMIT:   limit_reg = d[7:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (cadence_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic add_row(input logic act, input logic [7:0] b, input logic lst,
                         input bit typed, input logic [11:0] cad, input status_t st,
                         input logic [15:0] revs, input logic [15:0] etime);
    row_t row;
    row.act = act;
    row.b = b;
    row.lst = lst;
    row.typed = typed;
    row.res.cadence = cad;
    row.res.status = st;
    row.res.revs = revs;
    row.res.etime = etime;
    dir_rows.push_back(row);
  endtask

  task automatic random_frame();
    logic [7:0]  frame[$];
    logic [7:0]  fl;
    logic [15:0] r;
    logic [15:0] t;
    int          roll;
    int          n;
    bit          wheel;
    roll = $urandom_range(99);
    if (roll < 75) begin
      wheel = (roll >= 55);
      n = $urandom_range(99);
      if (n < 70) r = gen_revs + 16'($urandom_range(1, 3));
      else if (n < 80) r = gen_revs;
      else if (n < 90) r = gen_revs - 16'd1;
      else r = 16'($urandom_range(65535));
      n = $urandom_range(99);
      if (n < 70) t = gen_time + 16'($urandom_range(150, 3000));
      else if (n < 80) t = gen_time;
      else t = 16'($urandom_range(65535));
      frame.push_back(wheel ? FLAGS_WHEEL_CRANK : FLAGS_CRANK);
      if (wheel) repeat (6) frame.push_back(8'($urandom_range(255)));
      frame.push_back(r[7:0]);
      frame.push_back(r[15:8]);
      frame.push_back(t[7:0]);
      frame.push_back(t[15:8]);
      n = $urandom_range(99);
      n = (n < 80) ? 0 : (n < 95) ? $urandom_range(1, 4) : $urandom_range(20, 35);
      repeat (n) frame.push_back(8'($urandom_range(255)));
      gen_revs = r;
      gen_time = t;
    end else if (roll < 87) begin
      wheel = 1'($urandom_range(1));
      frame.push_back(wheel ? FLAGS_WHEEL_CRANK : FLAGS_CRANK);
      n = wheel ? $urandom_range(0, 9) : $urandom_range(0, 3);
      repeat (n) frame.push_back(8'($urandom_range(255)));
    end else begin
      do fl = 8'($urandom_range(255));
      while (fl == FLAGS_CRANK || fl == FLAGS_WHEEL_CRANK);
      frame.push_back(fl);
      repeat ($urandom_range(0, 12)) frame.push_back(8'($urandom_range(255)));
    end
    foreach (frame[i]) begin
      if ($urandom_range(99) < 3) send_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
      send_item(1'b0, frame[i], i == frame.size() - 1);
    end
  endtask

  initial begin
    int phase_end;
    rst_n = 1'b0;
    push = 1'b0;
    in_action = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    items_sent = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    typed_valid = 1'b0;
    typed_res = '0;
    frame_pos = '0;
    frame_flags = '0;
    revs_acc = '0;
    time_acc = '0;
    last_revs = '0;
    last_time = '0;
    cadence_now = '0;
    ms_idle = '0;
    timeout_reg = TIMEOUT_RST;
    limit_reg = LIMIT_RST;

    //      act   byte   last  typed cadence status      revs      time
    add_row(1'b0, 8'h00, 1'b1, 1'b1, 12'd0, ST_IGNORED, 16'h0000, 16'h0000);
    add_row(1'b0, 8'h02, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'h10, 1'b1, 1'b1, 12'd0, ST_SHORT,   16'h0000, 16'h0000);
    add_row(1'b0, 8'h02, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'hFF, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'hFF, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'hFF, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'hFF, 1'b1, 1'b1, 12'd0, ST_HELD,    16'hFFFF, 16'hFFFF);
    add_row(1'b1, 8'hFF, 1'b1, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'h03, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'hFF, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'h00, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'hFF, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'h00, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'hAA, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'h55, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'h00, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'h00, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'h00, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'h3C, 1'b1, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'h02, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'h00, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'h00, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'h00, 1'b0, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);
    add_row(1'b0, 8'h3C, 1'b1, 1'b0, 12'd0, ST_HELD,    16'h0000, 16'h0000);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      typed_valid = dir_rows[i].typed;
      typed_res = dir_rows[i].res;
      send_item(dir_rows[i].act, dir_rows[i].b, dir_rows[i].lst);
    end
    typed_valid = 1'b0;

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      @(posedge clk);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      case (p)
        1: send_idle_pct = 85;
        2: recv_stall_pct = 85;
        3, 6: begin
          send_idle_pct = 13;
          recv_stall_pct = 13;
        end
        4: hold_req = 1'b1;
        7: send_idle_pct = 85;
        default: ;
      endcase
      @(negedge clk);
      case (p)
        0: begin
          write_reg(CFG_TIMEOUT, 16'd0);
          write_reg(CFG_LIMIT, 16'd255);
        end
        1: begin
          write_reg(CFG_TIMEOUT, 16'd20);
          write_reg(CFG_LIMIT, 16'd120);
        end
        2: begin
          write_reg(CFG_TIMEOUT, 16'hFFFF);
          write_reg(CFG_LIMIT, 16'd1);
        end
        3: begin
          write_reg(CFG_SPARE_A, 16'($urandom_range(65535)));
          write_reg(CFG_TIMEOUT, 16'd8);
          write_reg(CFG_LIMIT, 16'h0100);  // low byte zero: every cadence dropped
        end
        4: begin
          write_reg(CFG_SPARE_B, 16'($urandom_range(65535)));
          write_reg(CFG_TIMEOUT, 16'($urandom_range(1, 60)));
          write_reg(CFG_LIMIT, 16'($urandom_range(1, 255)));
        end
        5: begin
          write_reg(CFG_TIMEOUT, 16'(TIMEOUT_RST));
          write_reg(CFG_LIMIT, 16'(LIMIT_RST));
        end
        6: begin
          write_reg(CFG_TIMEOUT, 16'($urandom_range(40)));
          write_reg(CFG_LIMIT, 16'($urandom_range(65535)));
        end
        default: begin
          write_reg(CFG_TIMEOUT, 16'd3);
          write_reg(CFG_LIMIT, 16'd200);
        end
      endcase
      valid <= 1'b0;
      tick_max = (timeout_reg <= 16'd40) ? 2 * timeout_reg + 3 : 12;
      gen_revs = last_revs;
      gen_time = last_time;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        repeat ($urandom_range(tick_max))
          send_item(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
        random_frame();
      end
    end

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
